// ===== rtl/rgb2hsv_pkg.sv =====
package rgb2hsv_pkg;

  // field widths
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 16;
  localparam int SAT_W  = 17;

  // hue divisor is six times the chroma, three bits above a channel
  localparam int HDIV_W = CHAN_W + 3;

  localparam int DEF_FRACTION_BITS = 16;

  typedef logic [CHAN_W-1:0] chan_t;

  // which channel holds the maximum
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  // remainders and divisors carried down the divider pipeline
  typedef struct packed {
    logic [HDIV_W-1:0] rem_h;
    logic [HDIV_W-1:0] div_h;
    chan_t             rem_s;
    chan_t             div_s;
    chan_t             bright;
  } div_state_t;

endpackage

// ===== rtl/rgb2hsv_pix_if.sv =====
interface rgb2hsv_pix_if;
  import rgb2hsv_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/rgb2hsv_hsv_if.sv =====
interface rgb2hsv_hsv_if;
  import rgb2hsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  chan_t            brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== rtl/rgb2hsv_prep.sv =====
module rgb2hsv_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgb2hsv_pkg::chan_t      red,
  input  rgb2hsv_pkg::chan_t      green,
  input  rgb2hsv_pkg::chan_t      blue,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgb2hsv_pkg::div_state_t out_state,
  output logic                    out_sat_int
);
  import rgb2hsv_pkg::*;

  localparam int EXT_W = HDIV_W - CHAN_W;

  // stage a: max, min and winning channel
  logic     a_valid_r;
  chan_t    a_red_r, a_green_r, a_blue_r, a_max_r, a_min_r;
  max_sel_t a_sel_r;
  max_sel_t a_sel_nxt;
  chan_t    a_max_nxt, a_min_nxt;

  // stage b: divider seeds
  logic       b_valid_r;
  div_state_t b_state_r;
  logic       b_sat_int_r;
  div_state_t b_state_nxt;
  logic       b_sat_int_nxt;

  logic en_a, en_b;

  logic [CHAN_W-1:0] d;
  logic [HDIV_W-1:0] hd, d6, num;
  chan_t             div_s;

  // each stage moves when empty or when the next one moves
  assign en_b     = !b_valid_r || out_ready;
  assign en_a     = !a_valid_r || en_b;
  assign in_ready = en_a;

  // max channel with red then green winning ties
  always_comb begin
    if (red >= green && red >= blue) begin
      a_sel_nxt = SEL_RED;
      a_max_nxt = red;
    end else if (green >= blue) begin
      a_sel_nxt = SEL_GREEN;
      a_max_nxt = green;
    end else begin
      a_sel_nxt = SEL_BLUE;
      a_max_nxt = blue;
    end
    a_min_nxt = red;
    if (green < a_min_nxt) a_min_nxt = green;
    if (blue < a_min_nxt) a_min_nxt = blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_red_r   <= red;
      a_green_r <= green;
      a_blue_r  <= blue;
      a_max_r   <= a_max_nxt;
      a_min_r   <= a_min_nxt;
      a_sel_r   <= a_sel_nxt;
    end
  end

  // chroma, hue numerator below six chroma, and saturation integer bit
  assign d  = a_max_r - a_min_r;
  assign hd = {{EXT_W{1'b0}}, d};
  assign d6 = (hd << 2) + (hd << 1);

  always_comb begin
    unique case (a_sel_r)
      SEL_RED: begin
        if (a_green_r >= a_blue_r) begin
          num = {{EXT_W{1'b0}}, a_green_r - a_blue_r};
        end else begin
          num = d6 - {{EXT_W{1'b0}}, a_blue_r - a_green_r};
        end
      end
      SEL_GREEN: begin
        num = (hd << 1) + {{EXT_W{1'b0}}, a_blue_r} - {{EXT_W{1'b0}}, a_red_r};
      end
      SEL_BLUE: begin
        num = (hd << 2) + {{EXT_W{1'b0}}, a_red_r} - {{EXT_W{1'b0}}, a_green_r};
      end
      default: begin
        num = '0;
      end
    endcase
  end

  // a zero divisor becomes one so black and grey pixels give zero
  assign div_s = (a_max_r == '0) ? chan_t'(1) : a_max_r;

  always_comb begin
    b_sat_int_nxt      = (d >= div_s);
    b_state_nxt.rem_h  = num;
    b_state_nxt.div_h  = (d == '0) ? HDIV_W'(1) : d6;
    b_state_nxt.div_s  = div_s;
    b_state_nxt.rem_s  = b_sat_int_nxt ? (d - div_s) : d;
    b_state_nxt.bright = a_max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_state_r   <= b_state_nxt;
      b_sat_int_r <= b_sat_int_nxt;
    end
  end

  assign out_valid   = b_valid_r;
  assign out_state   = b_state_r;
  assign out_sat_int = b_sat_int_r;

endmodule

// ===== rtl/rgb2hsv_div_stage.sv =====
module rgb2hsv_div_stage #(
  parameter int FB = rgb2hsv_pkg::DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgb2hsv_pkg::div_state_t in_state,
  input  logic [FB-1:0]           in_q_hue,
  input  logic [FB:0]             in_q_sat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgb2hsv_pkg::div_state_t out_state,
  output logic [FB-1:0]           out_q_hue,
  output logic [FB:0]             out_q_sat
);
  import rgb2hsv_pkg::*;

  logic              valid_r;
  div_state_t        state_r, state_nxt;
  logic [FB-1:0]     q_hue_r, q_hue_nxt;
  logic [FB:0]       q_sat_r, q_sat_nxt;
  logic              en;

  logic [HDIV_W:0]   th, dh;
  logic [CHAN_W:0]   ts, ds;
  logic              hbit, sbit;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  // one restoring step for each quotient
  assign th   = {in_state.rem_h, 1'b0};
  assign dh   = th - {1'b0, in_state.div_h};
  assign hbit = (th >= {1'b0, in_state.div_h});
  assign ts   = {in_state.rem_s, 1'b0};
  assign ds   = ts - {1'b0, in_state.div_s};
  assign sbit = (ts >= {1'b0, in_state.div_s});

  always_comb begin
    state_nxt       = in_state;
    state_nxt.rem_h = hbit ? dh[HDIV_W-1:0] : th[HDIV_W-1:0];
    state_nxt.rem_s = sbit ? ds[CHAN_W-1:0] : ts[CHAN_W-1:0];
    q_hue_nxt       = {in_q_hue[FB-2:0], hbit};
    q_sat_nxt       = {in_q_sat[FB-1:0], sbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      q_hue_r <= q_hue_nxt;
      q_sat_r <= q_sat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_state = state_r;
  assign out_q_hue = q_hue_r;
  assign out_q_sat = q_sat_r;

endmodule

// ===== rtl/rgb_to_hsv_converter_unit.sv =====
// each input beat passes prep stages a and b, then the divider stages, to the result
// throughput: one pixel per cycle, sustained, with no stall from the output side
// the pipeline depth is set by the dividers, one quotient bit per stage
// a held result stalls only the stages behind it; empty stages still fill
// reset (synchronous, active low) clears every stage valid bit; data is not reset
module rgb_to_hsv_converter_unit #(
  parameter int FRACTION_BITS = rgb2hsv_pkg::DEF_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rgb2hsv_pix_if.sink          in_pix,
  rgb2hsv_hsv_if.source        out_hsv
);
  import rgb2hsv_pkg::*;

  localparam int NSTG = FRACTION_BITS + 1;

  logic                   stg_valid [NSTG];
  logic                   stg_ready [NSTG];
  div_state_t             stg_state [NSTG];
  logic [FRACTION_BITS-1:0] stg_q_hue [NSTG];
  logic [FRACTION_BITS:0]   stg_q_sat [NSTG];

  logic                               sat_int;
  logic [HUE_W+FRACTION_BITS-1:0]     hue_ext;
  logic [SAT_W+FRACTION_BITS:0]       sat_ext;

  // max, min and divider seeds
  rgb2hsv_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_pix.valid),
    .in_ready    (in_pix.ready),
    .red         (in_pix.red),
    .green       (in_pix.green),
    .blue        (in_pix.blue),
    .out_valid   (stg_valid[0]),
    .out_ready   (stg_ready[0]),
    .out_state   (stg_state[0]),
    .out_sat_int (sat_int)
  );

  assign stg_q_hue[0] = '0;
  assign stg_q_sat[0] = {{FRACTION_BITS{1'b0}}, sat_int};

  // divider pipeline, one bit of both quotients per stage
  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
    rgb2hsv_div_stage #(
      .FB (FRACTION_BITS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[k]),
      .in_ready  (stg_ready[k]),
      .in_state  (stg_state[k]),
      .in_q_hue  (stg_q_hue[k]),
      .in_q_sat  (stg_q_sat[k]),
      .out_valid (stg_valid[k+1]),
      .out_ready (stg_ready[k+1]),
      .out_state (stg_state[k+1]),
      .out_q_hue (stg_q_hue[k+1]),
      .out_q_sat (stg_q_sat[k+1])
    );
  end

  // last stage register drives the result beat; quotients fit or are cut to field width
  assign hue_ext = {{HUE_W{1'b0}}, stg_q_hue[FRACTION_BITS]};
  assign sat_ext = {{SAT_W{1'b0}}, stg_q_sat[FRACTION_BITS]};

  assign out_hsv.valid      = stg_valid[FRACTION_BITS];
  assign stg_ready[FRACTION_BITS] = out_hsv.ready;
  assign out_hsv.hue        = hue_ext[HUE_W-1:0];
  assign out_hsv.saturation = sat_ext[SAT_W-1:0];
  assign out_hsv.brightness = stg_state[FRACTION_BITS].bright;

endmodule

// ===== rtl/rgb2hsv_chk.sv =====
module rgb2hsv_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rgb2hsv_pkg::HUE_W-1:0]  hue,
  input logic [rgb2hsv_pkg::SAT_W-1:0]  saturation,
  input rgb2hsv_pkg::chan_t             brightness
);
  import rgb2hsv_pkg::*;

  // reset empties the output stage
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // a stalled result beat stays
  a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result beat dropped");

  // a stalled result beat keeps its payload
  a_stall_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(hue) && $stable(saturation) && $stable(brightness))
    else $error("stalled result beat changed");

  // black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && brightness == '0 |-> hue == '0 && saturation == '0)
    else $error("black pixel with nonzero hue or saturation");

  // with the output stage empty the whole pipeline can move
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule

bind rgb_to_hsv_converter_unit rgb2hsv_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_pix.ready),
  .out_valid  (out_hsv.valid),
  .out_ready  (out_hsv.ready),
  .hue        (out_hsv.hue),
  .saturation (out_hsv.saturation),
  .brightness (out_hsv.brightness)
);
